### sv/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### sv/rcpwm_pkg.sv
// Shared constants and types of the RC PWM command decoder.
// Depends on nothing.
package rcpwm_pkg;
    localparam int NUM_CH = 4;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int STEP_BITS = 11;
    localparam logic [2:0] REG_ROUND_STEP = 3'd0;
    localparam logic [2:0] REG_YAW_SCALE = 3'd1;
    localparam logic [2:0] REG_CLIMB_SCALE = 3'd4;
    localparam logic [2:0] REG_OFFSETS = 3'd5;
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic tick;
        logic read_go;
    } lane_ctrl_t;
endpackage

### sv/rcpwm_lane.sv
// One channel lane: pulse width counter and iterative width-to-command mapper.
// Depends on rcpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rcpwm_lane #(
    parameter int COUNT_BITS = rcpwm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rcpwm_pkg::lane_ctrl_t    ctrl,
    input  logic                     pin,
    input  logic [10:0]              round_step,
    input  logic [63:0]              scale,
    input  logic [15:0]              offset,
    output logic                     done,
    output logic [15:0]              cmd
);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int XW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam int PW = XW + 17;
    localparam int QW = PW;
    localparam int CW = $clog2(QW + 2) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_FIN = 3'd4;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic                  prev_reg, prev_next;
    logic [15:0]           last_reg, last_next;
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         step_reg, step_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [PW-1:0]         num_reg, num_next;
    logic [QW-1:0]         quo_reg, quo_next;
    logic [PW-1:0]         part_reg, part_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;

    logic [15:0] in_low, in_high;
    logic signed [15:0] out_min, out_max;
    logic [10:0] step_eff;
    logic [COUNT_BITS-1:0] wq;
    logic signed [XW-1:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dn;
    logic signed [PW-1:0] prod;
    logic [16:0] dn_abs;
    logic [PW-1:0] trial;
    logic [PW-1:0] quo_s;
    logic signed [PW+1:0] r;
    logic in_range;
    logic [COUNT_BITS-1:0] rem_sub;

    assign in_low   = scale[15:0];
    assign in_high  = scale[31:16];
    assign out_min  = scale[47:32];
    assign out_max  = scale[63:48];
    assign step_eff = (round_step == 11'd0) ? 11'd1 : round_step;
    assign rem_sub  = rem_reg - COUNT_BITS'(step_eff);
    assign wq       = width_reg - rem_reg;
    assign dx       = $signed(XW'(wq)) - $signed(XW'(in_low));
    assign dy       = $signed({{2{out_max[15]}}, out_max}) - $signed({{2{out_min[15]}}, out_min});
    assign dn       = $signed({2'b00, in_high}) - $signed({2'b00, in_low});
    assign prod     = PW'(dx) * PW'(dy);
    assign dn_abs   = dn[17] ? 17'(-dn) : 17'(dn);
    assign trial    = {part_reg[PW-2:0], num_reg[PW-1]};
    assign quo_s    = neg_reg ? -quo_reg : quo_reg;
    assign r        = $signed({quo_s[PW-1], quo_s[PW-1], quo_s})
                      + (PW+2)'(out_min) + (PW+2)'($signed(offset));
    assign in_range = (r >= (PW+2)'(out_min)) && (r <= (PW+2)'(out_max));

    always_comb
    begin
        cnt_next   = cnt_reg;
        width_next = width_reg;
        prev_next  = prev_reg;
        last_next  = last_reg;
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        part_next  = part_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        if (ctrl.tick)
        begin
            if (pin)
            begin
                if (!prev_reg)
                    cnt_next = COUNT_BITS'(1);
                else if (cnt_reg != CNT_MAX)
                    cnt_next = cnt_reg + COUNT_BITS'(1);
            end
            else if (prev_reg)
            begin
                width_next = cnt_reg;
            end
            prev_next = pin;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.read_go)
                begin
                    rem_next   = width_reg;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (rem_reg >= COUNT_BITS'(step_eff))
                    rem_next = rem_sub;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                num_next   = prod[PW-1] ? -prod : prod;
                neg_next   = prod[PW-1] ^ dn[17];
                quo_next   = '0;
                part_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                num_next = {num_reg[PW-2:0], 1'b0};
                if (trial >= PW'(dn_abs))
                begin
                    part_next = trial - PW'(dn_abs);
                    quo_next  = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    part_next = trial;
                    quo_next  = {quo_reg[QW-2:0], 1'b0};
                end
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(PW - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (dn != 18'sd0 && in_range)
                    last_next = r[15:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            width_reg <= '0;
            prev_reg  <= 1'b0;
            last_reg  <= '0;
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            width_reg <= width_next;
            prev_reg  <= prev_next;
            last_reg  <= last_next;
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        part_reg <= part_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;
    assign cmd  = last_reg;

    `ASSERT_NEXT(a_go_leaves_idle, clk, rst_n, ctrl.read_go && state_reg == S_IDLE,
        state_reg == S_MOD)
    `ASSERT_NEXT(a_fin_done, clk, rst_n, state_reg == S_FIN, done_reg)
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
endmodule

### sv/rcpwm_merge.sv
// Merging stage: collects the four lane commands into one result register.
// Depends on rcpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rcpwm_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [rcpwm_pkg::NUM_CH-1:0] lane_done,
    input  logic [15:0]            lane_cmd [rcpwm_pkg::NUM_CH],
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [15:0]            res [rcpwm_pkg::NUM_CH]
);
    logic        valid_reg, valid_next;
    logic [rcpwm_pkg::NUM_CH-1:0] seen_reg, seen_next;
    logic [rcpwm_pkg::NUM_CH-1:0] seen_all;
    logic        fire;
    logic [15:0] res_reg [rcpwm_pkg::NUM_CH];

    // Lanes finish at different times, so each completion is remembered until all are in.
    assign seen_all = seen_reg | lane_done;
    assign fire     = &seen_all;

    always_comb
    begin
        valid_next = valid_reg;
        seen_next  = seen_all;
        if (fire)
        begin
            valid_next = 1'b1;
            seen_next  = '0;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= lane_cmd;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

    `ASSERT_IMPLIES(a_no_overrun, clk, rst_n, |lane_done, !valid_reg)
    `ASSERT_IMPLIES(a_seen_clear, clk, rst_n, valid_reg, seen_reg == '0)
    `ASSERT_NEXT(a_hold, clk, rst_n, valid_reg && !out_ready, valid_reg)
endmodule

### sv/rc_pwm_command_decoder_core.sv
// Four-channel RC receiver pulse width decoder.
// A read transfer finds each lane's remainder of the latched width by repeated subtraction
// of round_step, then maps the width through the per-lane shift-subtract divider, and the
// result is registered once all four lanes are done; one read at a time, and no new
// transfer is taken until the result has been accepted.
// Depends on rcpwm_pkg, rcpwm_lane and rcpwm_merge.
`include "assert_macros.svh"
module rc_pwm_command_decoder_core #(
    parameter int COUNT_BITS = rcpwm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        yaw_pin,
    input  logic        pitch_pin,
    input  logic        roll_pin,
    input  logic        climb_pin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] yaw_cmd,
    output logic [15:0] pitch_cmd,
    output logic [15:0] roll_cmd,
    output logic [15:0] climb_cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int NC = rcpwm_pkg::NUM_CH;

    logic [10:0] step_reg;
    logic [63:0] scale_reg [NC];
    logic [63:0] offs_reg;
    logic        busy_reg, busy_next;
    logic        accept;
    logic [NC-1:0] pins;
    logic [NC-1:0] lane_done;
    logic [15:0]   lane_cmd [NC];
    logic [15:0]   res [NC];
    rcpwm_pkg::lane_ctrl_t ctrl;

    assign pins     = {climb_pin, roll_pin, pitch_pin, yaw_pin};
    assign in_ready = !busy_reg && !out_valid;
    assign accept   = in_valid && in_ready;
    assign ctrl.tick    = accept && opcode == rcpwm_pkg::OP_TICK;
    assign ctrl.read_go = accept && opcode == rcpwm_pkg::OP_READ;

    always_comb
    begin
        busy_next = busy_reg;
        if (ctrl.read_go)
            busy_next = 1'b1;
        else if (out_valid)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= 11'd1;
            offs_reg  <= '0;
            for (int i = 0; i < NC; i++)
                scale_reg[i] <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_we)
            begin
                if (cfg_index == rcpwm_pkg::REG_ROUND_STEP)
                    step_reg <= cfg_data[10:0];
                else if (cfg_index >= rcpwm_pkg::REG_YAW_SCALE
                         && cfg_index <= rcpwm_pkg::REG_CLIMB_SCALE)
                    scale_reg[2'(cfg_index - rcpwm_pkg::REG_YAW_SCALE)] <= cfg_data;
                else if (cfg_index == rcpwm_pkg::REG_OFFSETS)
                    offs_reg <= cfg_data;
            end
        end
    end

    for (genvar g = 0; g < NC; g++)
    begin : g_lane
        rcpwm_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .pin        (pins[g]),
            .round_step (step_reg),
            .scale      (scale_reg[g]),
            .offset     (offs_reg[16*g +: 16]),
            .done       (lane_done[g]),
            .cmd        (lane_cmd[g])
        );
    end

    rcpwm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_done (lane_done),
        .lane_cmd  (lane_cmd),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res       (res)
    );

    assign yaw_cmd   = res[0];
    assign pitch_cmd = res[1];
    assign roll_cmd  = res[2];
    assign climb_cmd = res[3];

    `ASSERT_NEXT(a_read_busy, clk, rst_n, ctrl.read_go, busy_reg)
    `ASSERT_IMPLIES(a_done_when_busy, clk, rst_n, |lane_done, busy_reg)
    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, busy_reg, !in_ready)
endmodule
